@@ sv/ubx_pkg.sv @@
// ----------------------------------------------------------------------------
// ubx_pkg
// Shared types and constants for the UBX frame parser.
// ----------------------------------------------------------------------------
package ubx_pkg;

  localparam logic [7:0]  SYNC_ONE      = 8'hB5;
  localparam logic [7:0]  SYNC_TWO      = 8'h62;
  localparam logic [7:0]  EMPTY_CODE    = 8'hFF;
  localparam logic [15:0] MAX_LEN_RESET = 16'd512;

  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_FRAME    = 2'd1;
  localparam logic [1:0] KIND_TOO_LONG = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  frame_class;
    logic [7:0]  frame_id;
    logic [15:0] frame_length;
    logic [15:0] received_checksum;
    logic        checksum_ok;
  } ubx_res_t;

endpackage

@@ sv/ubx_fsm.sv @@
// ----------------------------------------------------------------------------
// ubx_fsm
// Frame state tracking: phase, header fields, running Fletcher sums, and
// the one result each accepted byte may cause.
// ----------------------------------------------------------------------------
module ubx_fsm
  import ubx_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_wdata,
  input  logic           byte_acc,
  input  logic [7:0]     rx_byte,
  output logic           res_valid,
  output ubx_res_t       res
);

  localparam logic [3:0] PH_SYNC1   = 4'd0;
  localparam logic [3:0] PH_SYNC2   = 4'd1;
  localparam logic [3:0] PH_CLASS   = 4'd2;
  localparam logic [3:0] PH_ID      = 4'd3;
  localparam logic [3:0] PH_LEN1    = 4'd4;
  localparam logic [3:0] PH_LEN2    = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_CSUMA   = 4'd7;
  localparam logic [3:0] PH_CSUMB   = 4'd8;

  logic [15:0] max_len_r;
  logic [3:0]  phase_r, phase_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] length_r, length_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  csum_a_r, csum_a_nxt;

  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] len_full;
  logic [15:0] count_inc;

  assign add_a     = sum_a_r + rx_byte;
  assign add_b     = sum_b_r + add_a;
  assign len_full  = {rx_byte, length_r[7:0]};
  assign count_inc = count_r + 16'd1;

  always_comb begin
    phase_nxt  = phase_r;
    class_nxt  = class_r;
    id_nxt     = id_r;
    length_nxt = length_r;
    count_nxt  = count_r;
    sum_a_nxt  = sum_a_r;
    sum_b_nxt  = sum_b_r;
    csum_a_nxt = csum_a_r;
    res_valid  = 1'b0;
    res.kind              = KIND_PAYLOAD;
    res.payload_byte      = 8'd0;
    res.payload_index     = 16'd0;
    res.frame_class       = class_r;
    res.frame_id          = id_r;
    res.frame_length      = length_r;
    res.received_checksum = 16'd0;
    res.checksum_ok       = 1'b0;

    case (phase_r)
      PH_SYNC1: begin
        if (rx_byte == SYNC_ONE) begin
          // restore frame values for the new frame
          class_nxt  = EMPTY_CODE;
          id_nxt     = EMPTY_CODE;
          length_nxt = 16'd0;
          count_nxt  = 16'd0;
          sum_a_nxt  = 8'd0;
          sum_b_nxt  = 8'd0;
          csum_a_nxt = 8'd0;
          phase_nxt  = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        phase_nxt = (rx_byte == SYNC_TWO) ? PH_CLASS : PH_SYNC1;
      end
      PH_CLASS: begin
        class_nxt = rx_byte;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        phase_nxt = PH_ID;
      end
      PH_ID: begin
        id_nxt    = rx_byte;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        phase_nxt = PH_LEN1;
      end
      PH_LEN1: begin
        length_nxt = {8'd0, rx_byte};
        sum_a_nxt  = add_a;
        sum_b_nxt  = add_b;
        phase_nxt  = PH_LEN2;
      end
      PH_LEN2: begin
        length_nxt = len_full;
        sum_a_nxt  = add_a;
        sum_b_nxt  = add_b;
        if (len_full > max_len_r) begin
          // drop oversized frame, report it
          phase_nxt        = PH_SYNC1;
          res_valid        = 1'b1;
          res.kind         = KIND_TOO_LONG;
          res.frame_length = len_full;
        end else if (len_full == 16'd0) begin
          phase_nxt = PH_CSUMA;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res_valid         = 1'b1;
        res.kind          = KIND_PAYLOAD;
        res.payload_byte  = rx_byte;
        res.payload_index = count_r;
        sum_a_nxt         = add_a;
        sum_b_nxt         = add_b;
        count_nxt         = count_inc;
        if (count_inc == length_r) begin
          phase_nxt = PH_CSUMA;
        end
      end
      PH_CSUMA: begin
        csum_a_nxt = rx_byte;
        phase_nxt  = PH_CSUMB;
      end
      PH_CSUMB: begin
        phase_nxt             = PH_SYNC1;
        res_valid             = 1'b1;
        res.kind              = KIND_FRAME;
        res.received_checksum = {csum_a_r, rx_byte};
        res.checksum_ok       = (csum_a_r == sum_a_r) && (rx_byte == sum_b_r);
      end
      default: begin
        phase_nxt = PH_SYNC1;
      end
    endcase

    if (!byte_acc) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SYNC1;
      class_r  <= EMPTY_CODE;
      id_r     <= EMPTY_CODE;
      length_r <= 16'd0;
      count_r  <= 16'd0;
      sum_a_r  <= 8'd0;
      sum_b_r  <= 8'd0;
      csum_a_r <= 8'd0;
    end else if (byte_acc) begin
      phase_r  <= phase_nxt;
      class_r  <= class_nxt;
      id_r     <= id_nxt;
      length_r <= length_nxt;
      count_r  <= count_nxt;
      sum_a_r  <= sum_a_nxt;
      sum_b_r  <= sum_b_nxt;
      csum_a_r <= csum_a_nxt;
    end
  end

endmodule

@@ sv/ubx_out_buf.sv @@
// ----------------------------------------------------------------------------
// ubx_out_buf
// Output register with a skid stage; ready toward the parser is registered.
// ----------------------------------------------------------------------------
module ubx_out_buf
  import ubx_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  ubx_res_t push_data,
  output logic     can_push,
  output logic     out_valid,
  input  logic     out_ready,
  output ubx_res_t out_data
);

  logic     out_valid_r;
  ubx_res_t out_data_r;
  logic     skid_valid_r;
  ubx_res_t skid_data_r;
  logic     out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign can_push  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        // drain skid first to keep order
        out_valid_r  <= 1'b1;
        skid_valid_r <= push;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r  <= skid_data_r;
        skid_data_r <= push_data;
      end else begin
        out_data_r <= push_data;
      end
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

@@ sv/ubx_frame_parser.sv @@
// ----------------------------------------------------------------------------
// ubx_frame_parser
// Recognizes UBX frames in a byte stream; emits payload bytes, frame results
// with checksum status, and oversize-length errors.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while in_ready is high; the phase and checksum
//   update is a single 8-bit add pair between the frame registers.
// Output: each result is registered into the output register, or into the skid stage.
// in_ready drops only while the skid stage holds a second waiting result.
// Reset (rst_n low, synchronous): hunt for the first sync byte, limit 512,
//   output and skid empty.
module ubx_frame_parser
  import ubx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_payload_index,
  output logic [7:0]  out_frame_class,
  output logic [7:0]  out_frame_id,
  output logic [15:0] out_frame_length,
  output logic [15:0] out_received_checksum,
  output logic        out_checksum_ok
);

  logic     byte_acc;
  logic     res_valid;
  ubx_res_t res;
  ubx_res_t out_data;

  assign byte_acc = in_valid && in_ready;

  ubx_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .byte_acc  (byte_acc),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  ubx_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_kind              = out_data.kind;
  assign out_payload_byte      = out_data.payload_byte;
  assign out_payload_index     = out_data.payload_index;
  assign out_frame_class       = out_data.frame_class;
  assign out_frame_id          = out_data.frame_id;
  assign out_frame_length      = out_data.frame_length;
  assign out_received_checksum = out_data.received_checksum;
  assign out_checksum_ok       = out_data.checksum_ok;

  a_payload_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_PAYLOAD |-> out_payload_index < out_frame_length)
    else $error("payload index beyond frame length");

  a_checksum_only_on_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_FRAME |-> !out_checksum_ok && out_received_checksum == 16'd0)
    else $error("checksum fields set on non-frame result");

  a_no_payload_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_PAYLOAD |-> out_payload_byte == 8'd0 && out_payload_index == 16'd0)
    else $error("payload fields set on non-payload result");

  a_kind_code_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind == KIND_PAYLOAD || out_kind == KIND_FRAME
                  || out_kind == KIND_TOO_LONG)
    else $error("unused result kind code");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Byte-stream test of the UBX frame parser: a queue-fed driver offers bytes,
// a tracking parser predicts payload, frame and oversize results, and the
// monitor compares every result transaction field by field. The payload
// limit is rewritten between phases while the parser is idle.
// ----------------------------------------------------------------------------
module tb
  import ubx_pkg::*;
;

  localparam int HOLD_CYCLES     = 80;
  localparam int STALL_LIMIT     = 2000;
  localparam int BYTES_PER_PHASE = 150;
  localparam int NUM_PHASES      = 6;

  typedef enum logic [3:0] {
    P_SYNC1, P_SYNC2, P_CLASS, P_ID, P_LEN_LO, P_LEN_HI, P_PAYLOAD, P_CSUM_A, P_CSUM_B
  } hunt_phase_e;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [15:0] cfg_wdata  = '0;
  logic        in_valid   = 1'b0;
  logic [7:0]  in_rx_byte = '0;
  logic        out_ready  = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [7:0]  out_payload_byte;
  logic [15:0] out_payload_index;
  logic [7:0]  out_frame_class;
  logic [7:0]  out_frame_id;
  logic [15:0] out_frame_length;
  logic [15:0] out_received_checksum;
  logic        out_checksum_ok;

  // stimulus and expectations
  logic [7:0] stream_bytes[$];
  ubx_res_t   parser_results[$];
  int         queued_bytes = 0;
  int         mismatches   = 0;
  int         stall_cycles = 0;
  logic       in_acc       = 1'b0;
  logic       no_idle      = 1'b0;
  logic       hold_req     = 1'b0;
  logic       hold_done    = 1'b0;
  int         hold_cnt     = 0;

  // tracking parser state
  hunt_phase_e m_phase  = P_SYNC1;
  logic [7:0]  m_class  = EMPTY_CODE;
  logic [7:0]  m_id     = EMPTY_CODE;
  logic [15:0] m_len    = '0;
  logic [15:0] m_count  = '0;
  logic [7:0]  m_sum_a  = '0;
  logic [7:0]  m_sum_b  = '0;
  logic [15:0] m_rx_csum = '0;
  logic [15:0] limit_cfg = MAX_LEN_RESET;

  ubx_frame_parser DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_kind             (out_kind),
    .out_payload_byte     (out_payload_byte),
    .out_payload_index    (out_payload_index),
    .out_frame_class      (out_frame_class),
    .out_frame_id         (out_frame_id),
    .out_frame_length     (out_frame_length),
    .out_received_checksum(out_received_checksum),
    .out_checksum_ok      (out_checksum_ok)
  );

  always #5 clk = ~clk;

  function automatic void fold_sum(input logic [7:0] b);
    m_sum_a = m_sum_a + b;
    m_sum_b = m_sum_b + m_sum_a;
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b);
    ubx_res_t r;
    logic     emit;
    r    = '0;
    emit = 1'b0;
    case (m_phase)
      P_SYNC1: if (b == SYNC_ONE) begin
        m_class   = EMPTY_CODE;
        m_id      = EMPTY_CODE;
        m_len     = '0;
        m_count   = '0;
        m_sum_a   = '0;
        m_sum_b   = '0;
        m_rx_csum = '0;
        m_phase   = P_SYNC2;
      end
      P_SYNC2: m_phase = (b == SYNC_TWO) ? P_CLASS : P_SYNC1;
      P_CLASS: begin
        m_class = b;
        fold_sum(b);
        m_phase = P_ID;
      end
      P_ID: begin
        m_id = b;
        fold_sum(b);
        m_phase = P_LEN_LO;
      end
      P_LEN_LO: begin
        m_len = {8'h00, b};
        fold_sum(b);
        m_phase = P_LEN_HI;
      end
      P_LEN_HI: begin
        m_len[15:8] = b;
        fold_sum(b);
        if (m_len > limit_cfg) begin
          m_phase = P_SYNC1;
          emit    = 1'b1;
          r.kind  = KIND_TOO_LONG;
        end else begin
          m_phase = (m_len == 16'd0) ? P_CSUM_A : P_PAYLOAD;
        end
      end
      P_PAYLOAD: begin
        emit            = 1'b1;
        r.kind          = KIND_PAYLOAD;
        r.payload_byte  = b;
        r.payload_index = m_count;
        fold_sum(b);
        m_count = m_count + 16'd1;
        if (m_count == m_len) m_phase = P_CSUM_A;
      end
      P_CSUM_A: begin
        m_rx_csum = {b, 8'h00};
        m_phase   = P_CSUM_B;
      end
      P_CSUM_B: begin
        m_rx_csum[7:0]      = b;
        emit                = 1'b1;
        r.kind              = KIND_FRAME;
        r.received_checksum = m_rx_csum;
        r.checksum_ok       = (m_rx_csum == {m_sum_a, m_sum_b});
        m_phase             = P_SYNC1;
      end
      default: m_phase = P_SYNC1;
    endcase
    if (emit) begin
      r.frame_class  = m_class;
      r.frame_id     = m_id;
      r.frame_length = m_len;
      parser_results.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("tb: mismatch on %s at %0t: got 0x%0h, expected 0x%0h", what, $time, got, want);
    mismatches++;
  endtask

  task automatic check_result();
    ubx_res_t want;
    if (parser_results.size() == 0) begin
      report_mismatch("unexpected result kind", 16'(out_kind), 16'd0);
      return;
    end
    want = parser_results.pop_front();
    if (out_kind !== want.kind) report_mismatch("kind", 16'(out_kind), 16'(want.kind));
    if (out_payload_byte !== want.payload_byte)
      report_mismatch("payload_byte", 16'(out_payload_byte), 16'(want.payload_byte));
    if (out_payload_index !== want.payload_index)
      report_mismatch("payload_index", out_payload_index, want.payload_index);
    if (out_frame_class !== want.frame_class)
      report_mismatch("frame_class", 16'(out_frame_class), 16'(want.frame_class));
    if (out_frame_id !== want.frame_id)
      report_mismatch("frame_id", 16'(out_frame_id), 16'(want.frame_id));
    if (out_frame_length !== want.frame_length)
      report_mismatch("frame_length", out_frame_length, want.frame_length);
    if (out_received_checksum !== want.received_checksum)
      report_mismatch("received_checksum", out_received_checksum, want.received_checksum);
    if (out_checksum_ok !== want.checksum_ok)
      report_mismatch("checksum_ok", 16'(out_checksum_ok), 16'(want.checksum_ok));
  endtask

  // Sample both channels; predict on every input transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_acc       <= 1'b0;
      stall_cycles <= 0;
    end else begin
      in_acc <= in_valid && in_ready;
      if (in_valid && in_ready) parse_rx_byte(in_rx_byte);
      if (out_valid && out_ready) check_result();
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Byte driver: hold the payload until the transaction completes.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (stream_bytes.size() > 0 && (no_idle || $urandom_range(0, 99) >= 36)) begin
        in_valid   <= 1'b1;
        in_rx_byte <= stream_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver, with one long hold-off once results start arriving.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done && (hold_cnt > 0 || parser_results.size() > 0)) begin
      if (hold_cnt == HOLD_CYCLES) begin
        hold_done <= 1'b1;
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        hold_cnt  <= hold_cnt + 1;
      end
    end else begin
      out_ready <= no_idle || ($urandom_range(0, 99) >= 36);
    end
  end

  task automatic put_byte(input logic [7:0] b);
    stream_bytes.push_back(b);
    queued_bytes++;
  endtask

  // Queue one frame; cut >= 0 truncates it after that many payload bytes.
  task automatic queue_frame(input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] len, input bit bad_csum, input int cut);
    logic [7:0]  sa;
    logic [7:0]  sb;
    logic [7:0]  pb;
    logic [31:0] hdr;
    logic [15:0] csum;
    int          n;
    sa  = '0;
    sb  = '0;
    hdr = {len[15:8], len[7:0], id, cls};
    put_byte(SYNC_ONE);
    put_byte(SYNC_TWO);
    for (int i = 0; i < 4; i++) begin
      put_byte(hdr[8*i +: 8]);
      sa = sa + hdr[8*i +: 8];
      sb = sb + sa;
    end
    if (len > limit_cfg) return;
    n = (cut >= 0) ? cut : int'(len);
    for (int i = 0; i < n; i++) begin
      pb = 8'($urandom_range(0, 255));
      put_byte(pb);
      sa = sa + pb;
      sb = sb + sa;
    end
    if (cut >= 0) return;
    csum = {sa, sb};
    if (bad_csum) csum = csum ^ (16'h0001 << $urandom_range(0, 15));
    put_byte(csum[15:8]);
    put_byte(csum[7:0]);
  endtask

  // Parser is idle once all bytes are taken and no result is outstanding.
  task automatic wait_drained();
    while (stream_bytes.size() > 0 || in_valid || parser_results.size() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    limit_cfg = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] limit_plan[NUM_PHASES];
    logic [7:0]  b;
    int          sel;
    int          cap;
    int          lim;
    int          len;
    limit_plan[0] = MAX_LEN_RESET;
    limit_plan[1] = 16'd0;
    limit_plan[2] = 16'hFFFF;
    limit_plan[3] = 16'd1;
    limit_plan[4] = 16'd7;
    limit_plan[5] = 16'($urandom_range(2, 60));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_limit(limit_plan[ph]);
      no_idle      = (ph == 3);
      hold_req     = (ph == 2);
      queued_bytes = 0;
      lim          = int'(limit_plan[ph]);

      if (ph == 0) begin
        put_byte(8'h00);                    // ignored while hunting
        put_byte(8'hFF);
        put_byte(SYNC_ONE);                 // bad second sync byte
        put_byte(8'h00);
        queue_frame(8'hFF, 8'hFF, 16'd0, 1'b0, -1);    // zero length
        queue_frame(8'h00, 8'h00, 16'd1, 1'b1, -1);    // checksum error
        queue_frame(8'h01, 8'h02, 16'hFFFF, 1'b0, -1); // length over limit
      end

      while (queued_bytes < BYTES_PER_PHASE) begin
        sel = $urandom_range(0, 99);
        cap = ($urandom_range(0, 9) == 0) ? 48 : 12;
        if (cap > lim) cap = lim;
        len = $urandom_range(0, cap);
        if (sel < 5) begin
          // noise, kept free of the first sync byte
          repeat ($urandom_range(1, 4)) begin
            b = 8'($urandom_range(0, 255));
            if (b == SYNC_ONE) b = 8'h00;
            put_byte(b);
          end
        end else if (sel < 10) begin
          b = 8'($urandom_range(0, 255));
          if (b == SYNC_TWO) b = 8'hFF;
          put_byte(SYNC_ONE);
          put_byte(b);
        end else if (sel < 17 && lim < 65535) begin
          queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      16'($urandom_range(lim + 1, 65535)), 1'b0, -1);
        end else if (sel < 22 && len >= 2) begin
          queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'(len),
                      1'b0, $urandom_range(1, len - 1));
        end else begin
          queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'(len),
                      sel < 32, -1);
        end
      end
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/ubx_pkg.sv
sv/ubx_fsm.sv
sv/ubx_out_buf.sv
sv/ubx_frame_parser.sv
test/tb.sv
